>>> rtl/core/vdt_pkg.sv
// Shared types and constants for the vertex dedup table.
// No dependencies; imported by every module of the block.
package vdt_pkg;

    localparam int MAX_ENTRIES = 4096;
    localparam int ADDR_W      = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int FLOAT_W     = 32;
    localparam int IDX_W       = 12;

    // One vertex. Declared high to low so that pos_x sits in the lowest bits.
    typedef struct packed {
        logic [FLOAT_W-1:0] norm_z;
        logic [FLOAT_W-1:0] norm_y;
        logic [FLOAT_W-1:0] norm_x;
        logic [FLOAT_W-1:0] uv_v;
        logic [FLOAT_W-1:0] uv_u;
        logic [FLOAT_W-1:0] pos_z;
        logic [FLOAT_W-1:0] pos_y;
        logic [FLOAT_W-1:0] pos_x;
    } vertex_t;

    localparam int VERTEX_W = $bits(vertex_t);

    // Port request into the vertex store.
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_FIN  = 3'b100
    } state_t;

    function automatic logic is_nan(input logic [FLOAT_W-1:0] b);
        return (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    endfunction

    // IEEE equality: signed zeros match, NaN never matches.
    function automatic logic ieee_eq(input logic [FLOAT_W-1:0] a,
                                     input logic [FLOAT_W-1:0] b);
        logic r;
        if (is_nan(a) || is_nan(b))
        begin
            r = 1'b0;
        end
        else if (((a | b) & 32'h7FFF_FFFF) == 32'd0)
        begin
            r = 1'b1;
        end
        else
        begin
            r = (a == b);
        end
        return r;
    endfunction

endpackage

>>> rtl/core/vertex_dedup_table_core.sv
// Vertex dedup table top level: scan sequencer, fill count, output register.
// Depends on vdt_pkg, vdt_mem, vdt_match.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-------------------------------------------
//  s_      | in  | s_tvalid/s_tready  | s_tdata: one vertex, eight IEEE singles
//  m_      | out | m_tvalid/m_tready  | m_tdata: vertex_index; m_tuser: flags
//
// Scan: a request is compared against the n stored entries; the scan reads one
//   entry per cycle through the single store read port, and stops in the cycle
//   after it reads the first matching entry, when its registered data is compared.
// Reset: clears only the fill count and control; the store needs no clearing
//   pass since only entries below the fill count are ever read.
// Stalls: a finished result sits in the output register, so the next request
//   is taken while m_tready is low; a second result waits in FIN for room.
module vertex_dedup_table_core
    import vdt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [VERTEX_W-1:0]  s_tdata,   // pos_x, pos_y, pos_z, uv_u, uv_v,
                                            // norm_x, norm_y, norm_z (32b each)
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [15:0]          m_tdata,   // vertex_index[11:0], zero pad
    output logic [1:0]           m_tuser    // was_added, table_full
);

    state_t            state_reg,     state_next;
    logic [CNT_W-1:0]  count_reg,     count_next;
    logic [CNT_W-1:0]  issue_reg,     issue_next;
    logic              pend_reg,      pend_next;
    logic [ADDR_W-1:0] pend_idx_reg,  pend_idx_next;
    vertex_t           key_reg,       key_next;
    logic [IDX_W-1:0]  res_idx_reg,   res_idx_next;
    logic              res_add_reg,   res_add_next;
    logic              res_full_reg,  res_full_next;
    logic              out_vld_reg,   out_vld_next;
    logic [IDX_W-1:0]  out_idx_reg,   out_idx_next;
    logic              out_add_reg,   out_add_next;
    logic              out_full_reg,  out_full_next;

    mem_req_t mem_req;
    vertex_t  mem_rdata;
    logic     hit;
    logic     s_fire;

    vdt_mem u_mem (
        .clk   (clk),
        .req   (mem_req),
        .wdata (key_reg),
        .rdata (mem_rdata)
    );

    vdt_match u_match (
        .key   (key_reg),
        .entry (mem_rdata),
        .hit   (hit)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;

    // Appended entry is at the fill count and is never read during the scan
    // that writes it, so no forwarding is needed.
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        issue_next    = issue_reg;
        pend_next     = 1'b0;
        pend_idx_next = pend_idx_reg;
        key_next      = key_reg;
        res_idx_next  = res_idx_reg;
        res_add_next  = res_add_reg;
        res_full_next = res_full_reg;
        out_vld_next  = out_vld_reg && !m_tready;
        out_idx_next  = out_idx_reg;
        out_add_next  = out_add_reg;
        out_full_next = out_full_reg;
        mem_req       = '0;
        mem_req.raddr = issue_reg[ADDR_W-1:0];
        mem_req.waddr = count_reg[ADDR_W-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_fire)
                begin
                    key_next   = vertex_t'(s_tdata);
                    issue_next = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                priority if (pend_reg && hit)
                begin
                    res_idx_next  = IDX_W'(pend_idx_reg);
                    res_add_next  = 1'b0;
                    res_full_next = 1'b0;
                    state_next    = ST_FIN;
                end
                else if (!pend_reg && (issue_reg >= count_reg))
                begin
                    if (count_reg == CNT_W'(MAX_ENTRIES))
                    begin
                        res_idx_next  = '0;
                        res_add_next  = 1'b0;
                        res_full_next = 1'b1;
                    end
                    else
                    begin
                        mem_req.we    = 1'b1;
                        count_next    = count_reg + 1'b1;
                        res_idx_next  = IDX_W'(count_reg[ADDR_W-1:0]);
                        res_add_next  = 1'b1;
                        res_full_next = 1'b0;
                    end
                    state_next = ST_FIN;
                end
                else if (issue_reg < count_reg)
                begin
                    mem_req.re    = 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = issue_reg[ADDR_W-1:0];
                    issue_next    = issue_reg + 1'b1;
                end
                else
                begin
                    // last read compared without a hit; finish next cycle
                    pend_next = 1'b0;
                end
            end
            ST_FIN:
            begin
                if (!out_vld_reg || m_tready)
                begin
                    out_vld_next  = 1'b1;
                    out_idx_next  = res_idx_reg;
                    out_add_next  = res_add_reg;
                    out_full_next = res_full_reg;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            issue_reg   <= '0;
            pend_reg    <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            issue_reg   <= issue_next;
            pend_reg    <= pend_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_idx_reg <= pend_idx_next;
        key_reg      <= key_next;
        res_idx_reg  <= res_idx_next;
        res_add_reg  <= res_add_next;
        res_full_reg <= res_full_next;
        out_idx_reg  <= out_idx_next;
        out_add_reg  <= out_add_next;
        out_full_reg <= out_full_next;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {{(16 - IDX_W){1'b0}}, out_idx_reg};
    assign m_tuser  = {out_full_reg, out_add_reg};

endmodule

>>> rtl/core/vdt_mem.sv
// Vertex store: one synchronous RAM, one write and one read port,
// registered read data. Depends on vdt_pkg.
module vdt_mem
    import vdt_pkg::*;
(
    input  logic     clk,
    input  mem_req_t req,
    input  vertex_t  wdata,
    output vertex_t  rdata
);

    vertex_t store_mem [MAX_ENTRIES];
    vertex_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            store_mem[req.waddr] <= wdata;
        end
        if (req.re)
        begin
            rdata_reg <= store_mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/vdt_match.sv
// Field-wise IEEE compare of the search key against one stored vertex.
// Depends on vdt_pkg (vertex_t, ieee_eq).
module vdt_match
    import vdt_pkg::*;
(
    input  vertex_t key,
    input  vertex_t entry,
    output logic    hit
);

    assign hit = ieee_eq(key.pos_x,  entry.pos_x)  &&
                 ieee_eq(key.pos_y,  entry.pos_y)  &&
                 ieee_eq(key.pos_z,  entry.pos_z)  &&
                 ieee_eq(key.uv_u,   entry.uv_u)   &&
                 ieee_eq(key.uv_v,   entry.uv_v)   &&
                 ieee_eq(key.norm_x, entry.norm_x) &&
                 ieee_eq(key.norm_y, entry.norm_y) &&
                 ieee_eq(key.norm_z, entry.norm_z);

endmodule
